/* design/rsc_pkg.sv */
// Shared word types, request codes and register indexes for the rotor substitution cipher.
package rsc_pkg;

    localparam int LETTER_W    = 5;
    localparam int LETTER_CODES = 2 ** LETTER_W;
    localparam int REQ_TYPE_W  = 2;
    localparam int ROTOR_SEL_W = 2;
    localparam int CFG_INDEX_W = 1;

    // Request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_ENCRYPT = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_DECRYPT = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_LOAD    = 2'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_SET     = 2'd3;

    // Rotor select codes
    localparam logic [ROTOR_SEL_W-1:0] ROTOR_FAST   = 2'd0;
    localparam logic [ROTOR_SEL_W-1:0] ROTOR_MIDDLE = 2'd1;
    localparam logic [ROTOR_SEL_W-1:0] ROTOR_SLOW   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_NOTCH_FAST   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NOTCH_MIDDLE = 1'b1;

    // Output queue
    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

    typedef struct packed {
        logic [REQ_TYPE_W-1:0]  req_type;
        logic [LETTER_W-1:0]    letter;
        logic [ROTOR_SEL_W-1:0] rotor_sel;
        logic [LETTER_W-1:0]    entry_index;
        logic [LETTER_W-1:0]    entry_letter;
        logic [LETTER_W-1:0]    start_fast;
        logic [LETTER_W-1:0]    start_middle;
        logic [LETTER_W-1:0]    start_slow;
    } req_t;

    typedef struct packed {
        logic [LETTER_W-1:0] out_letter;
        logic                letter_valid;
    } rsp_t;

endpackage

/* design/rotor_substitution_cipher.sv */
// Top level of the three-rotor substitution cipher: wiring memories, rotor stepping and pipeline.
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+----------------------------------------
//  req     | in        | req_valid / req_ready | rsc_pkg::req_t (encrypt, decrypt, set-up)
//  rsp     | out       | rsp_valid / rsp_ready | rsc_pkg::rsp_t, one word per req word
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index + cfg_data (notch registers)
//
//  One req word per cycle while req_ready is high; each word passes stages s1 to s4 and
//  the output queue before it leaves on rsp. The pipeline holds the three dependent wiring
//  lookups, one synchronous memory read per stage. Reset clears positions, notches, pipeline
//  valids and the output queue; wiring memories come up undefined and need no clearing pass.
//  A stalled rsp side fills an eight-word output queue; req_ready drops only once eight
//  words are in flight. cfg_ready is always high.
module rotor_substitution_cipher #(
    parameter int ALPHABET_SIZE = 26
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  rsc_pkg::req_t                       req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output rsc_pkg::rsp_t                       rsp,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rsc_pkg::LETTER_W-1:0]        cfg_data
);
    import rsc_pkg::*;

    // Letter and position width inside the block
    localparam int LW = $clog2(ALPHABET_SIZE);
    localparam int CNT_W = OQ_PTR_W + 1;

    // Item context carried down the pipeline. p1..p3 are the rotor positions in the
    // order the letter visits them (fast first for encrypt, slow first for decrypt).
    typedef struct packed {
        logic                   xform;
        logic                   enc;
        logic [LW-1:0]          v;
        logic [LW-1:0]          p1;
        logic [LW-1:0]          p2;
        logic [LW-1:0]          p3;
        logic                   ld;
        logic [ROTOR_SEL_W-1:0] sel;
        logic [LW-1:0]          idx;
        logic [LW-1:0]          ltr;
    } stage_t;

    function automatic logic [LW-1:0] wrap_add(input logic [LW-1:0] a, input logic [LW-1:0] b);
        logic [LW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (LW+1)'(ALPHABET_SIZE))
        begin
            s = s - (LW+1)'(ALPHABET_SIZE);
        end
        return s[LW-1:0];
    endfunction

    function automatic logic [LW-1:0] wrap_sub(input logic [LW-1:0] a, input logic [LW-1:0] b);
        logic [LW:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (a < b)
        begin
            d = d + (LW+1)'(ALPHABET_SIZE);
        end
        return d[LW-1:0];
    endfunction

    function automatic logic [LW-1:0] wrap_inc(input logic [LW-1:0] a);
        logic [LW-1:0] r;
        if (a == LW'(ALPHABET_SIZE - 1))
        begin
            r = '0;
        end
        else
        begin
            r = a + LW'(1);
        end
        return r;
    endfunction

    // Reduce a raw 5-bit start value into the alphabet: constant table.
    logic [LW-1:0] mod_tbl [LETTER_CODES];
    for (genvar gi = 0; gi < LETTER_CODES; gi++)
    begin : g_mod_tbl
        assign mod_tbl[gi] = LW'(gi % ALPHABET_SIZE);
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LETTER_W-1:0] notch_fast_reg;
    logic [LETTER_W-1:0] notch_middle_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            notch_fast_reg   <= '0;
            notch_middle_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NOTCH_FAST:   notch_fast_reg   <= cfg_data;
                CFG_NOTCH_MIDDLE: notch_middle_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Wiring memories, one bank per rotor and direction. Each bank is written at the
    // pipeline stage just before the stage that reads it, so reads and writes land in
    // word order without an interlock.
    // ------------------------------------------------------------------
    logic [LW-1:0] fw0_mem [ALPHABET_SIZE];
    logic [LW-1:0] fw1_mem [ALPHABET_SIZE];
    logic [LW-1:0] fw2_mem [ALPHABET_SIZE];
    logic [LW-1:0] iv0_mem [ALPHABET_SIZE];
    logic [LW-1:0] iv1_mem [ALPHABET_SIZE];
    logic [LW-1:0] iv2_mem [ALPHABET_SIZE];

    logic [LW-1:0] fw0_rd_reg, fw1_rd_reg, fw2_rd_reg;
    logic [LW-1:0] iv0_rd_reg, iv1_rd_reg, iv2_rd_reg;
    // Wired letter at the current fast and middle positions, for the carry decision
    logic [LW-1:0] pf0_reg, pf1_reg;

    // ------------------------------------------------------------------
    // Pipeline and rotor state
    // ------------------------------------------------------------------
    logic          s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    stage_t        s1_reg, s2_reg, s3_reg, s4_reg;
    stage_t        s1_next;

    logic [LW-1:0] fast_pos_reg, middle_pos_reg, slow_pos_reg;
    logic [LW-1:0] fast_pos_next, middle_pos_next, slow_pos_next;

    logic          req_acc;
    logic          letter_ok;
    logic          load_ok;
    logic          carry_fast;
    logic          carry_middle;
    logic [LW-1:0] pf1_fwd;

    // Output queue and in-flight count
    rsp_t             oq_mem [OQ_DEPTH];
    logic [CNT_W-1:0] oq_wr_ptr_reg, oq_rd_ptr_reg;
    logic [CNT_W-1:0] inflight_reg, inflight_next;
    logic             rsp_pop;

    assign req_ready = (inflight_reg != CNT_W'(OQ_DEPTH));
    assign req_acc   = req_valid && req_ready;

    assign letter_ok = ({1'b0, req.letter} < (LETTER_W+1)'(ALPHABET_SIZE));
    assign load_ok   = (req.req_type == REQ_LOAD) && (req.rotor_sel <= ROTOR_SLOW)
                       && ({1'b0, req.entry_index} < (LETTER_W+1)'(ALPHABET_SIZE))
                       && ({1'b0, req.entry_letter} < (LETTER_W+1)'(ALPHABET_SIZE));

    // Middle-rotor wiring written one stage after accept: forward a load still in
    // stage 1 to the word accepted right behind it.
    assign pf1_fwd = (s1_vld_reg && s1_reg.ld && s1_reg.sel == ROTOR_MIDDLE
                      && s1_reg.idx == middle_pos_reg) ? s1_reg.ltr : pf1_reg;

    assign carry_fast   = (LETTER_W'(pf0_reg) == notch_fast_reg);
    assign carry_middle = carry_fast && (LETTER_W'(pf1_fwd) == notch_middle_reg);

    // Step rotors, set positions, and build the stage-1 context
    always_comb
    begin
        fast_pos_next   = fast_pos_reg;
        middle_pos_next = middle_pos_reg;
        slow_pos_next   = slow_pos_reg;

        s1_next       = '0;
        s1_next.enc   = (req.req_type == REQ_ENCRYPT);
        s1_next.xform = ((req.req_type == REQ_ENCRYPT) || (req.req_type == REQ_DECRYPT))
                        && letter_ok;
        s1_next.v     = req.letter[LW-1:0];
        s1_next.ld    = load_ok;
        s1_next.sel   = req.rotor_sel;
        s1_next.idx   = req.entry_index[LW-1:0];
        s1_next.ltr   = req.entry_letter[LW-1:0];

        if (req_acc)
        begin
            if (req.req_type == REQ_SET)
            begin
                fast_pos_next   = mod_tbl[req.start_fast];
                middle_pos_next = mod_tbl[req.start_middle];
                slow_pos_next   = mod_tbl[req.start_slow];
            end
            else if (s1_next.xform)
            begin
                fast_pos_next = wrap_inc(fast_pos_reg);
                if (carry_fast)
                begin
                    middle_pos_next = wrap_inc(middle_pos_reg);
                end
                if (carry_middle)
                begin
                    slow_pos_next = wrap_inc(slow_pos_reg);
                end
            end
        end

        s1_next.p1 = s1_next.enc ? fast_pos_next : slow_pos_next;
        s1_next.p2 = middle_pos_next;
        s1_next.p3 = s1_next.enc ? slow_pos_next : fast_pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_pos_reg   <= '0;
            middle_pos_reg <= '0;
            slow_pos_reg   <= '0;
            s1_vld_reg     <= 1'b0;
            s2_vld_reg     <= 1'b0;
            s3_vld_reg     <= 1'b0;
            s4_vld_reg     <= 1'b0;
        end
        else
        begin
            fast_pos_reg   <= fast_pos_next;
            middle_pos_reg <= middle_pos_next;
            slow_pos_reg   <= slow_pos_next;
            s1_vld_reg     <= req_acc;
            s2_vld_reg     <= s1_vld_reg;
            s3_vld_reg     <= s2_vld_reg;
            s4_vld_reg     <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s1_reg;
        s3_reg <= s2_reg;
        s4_reg <= s3_reg;
    end

    // Lookup addresses and data per stage
    logic [LW-1:0] addr1, addr2, addr3;
    logic [LW-1:0] d1, d2, d3;
    logic [LW-1:0] result;

    assign addr1  = wrap_add(s1_reg.v, s1_reg.p1);
    assign d1     = s2_reg.enc ? fw0_rd_reg : iv2_rd_reg;
    assign addr2  = wrap_add(wrap_sub(d1, s2_reg.p1), s2_reg.p2);
    assign d2     = s3_reg.enc ? fw1_rd_reg : iv1_rd_reg;
    assign addr3  = wrap_add(wrap_sub(d2, s3_reg.p2), s3_reg.p3);
    assign d3     = s4_reg.enc ? fw2_rd_reg : iv0_rd_reg;
    assign result = wrap_sub(d3, s4_reg.p3);

    // Write enables: fast forward and slow inverse at accept, middle at stage 1,
    // slow forward and fast inverse at stage 2.
    logic wr_fw0, wr_iv2, wr_s1_mid, wr_fw2, wr_iv0;

    assign wr_fw0    = req_acc && load_ok && (req.rotor_sel == ROTOR_FAST);
    assign wr_iv2    = req_acc && load_ok && (req.rotor_sel == ROTOR_SLOW);
    assign wr_s1_mid = s1_vld_reg && s1_reg.ld && (s1_reg.sel == ROTOR_MIDDLE);
    assign wr_fw2    = s2_vld_reg && s2_reg.ld && (s2_reg.sel == ROTOR_SLOW);
    assign wr_iv0    = s2_vld_reg && s2_reg.ld && (s2_reg.sel == ROTOR_FAST);

    // Fast forward bank: stage-1 lookup plus carry read at the next fast position
    always_ff @(posedge clk)
    begin
        if (wr_fw0)
        begin
            fw0_mem[s1_next.idx] <= s1_next.ltr;
        end
        fw0_rd_reg <= fw0_mem[addr1];
        if (wr_fw0 && s1_next.idx == fast_pos_next)
        begin
            pf0_reg <= s1_next.ltr;
        end
        else
        begin
            pf0_reg <= fw0_mem[fast_pos_next];
        end
    end

    // Slow inverse bank: stage-1 lookup for decrypt
    always_ff @(posedge clk)
    begin
        if (wr_iv2)
        begin
            iv2_mem[s1_next.ltr] <= s1_next.idx;
        end
        iv2_rd_reg <= iv2_mem[addr1];
    end

    // Middle forward bank: stage-2 lookup plus carry read at the next middle position
    always_ff @(posedge clk)
    begin
        if (wr_s1_mid)
        begin
            fw1_mem[s1_reg.idx] <= s1_reg.ltr;
        end
        fw1_rd_reg <= fw1_mem[addr2];
        if (wr_s1_mid && s1_reg.idx == middle_pos_next)
        begin
            pf1_reg <= s1_reg.ltr;
        end
        else
        begin
            pf1_reg <= fw1_mem[middle_pos_next];
        end
    end

    // Middle inverse bank
    always_ff @(posedge clk)
    begin
        if (wr_s1_mid)
        begin
            iv1_mem[s1_reg.ltr] <= s1_reg.idx;
        end
        iv1_rd_reg <= iv1_mem[addr2];
    end

    // Slow forward bank: stage-3 lookup for encrypt
    always_ff @(posedge clk)
    begin
        if (wr_fw2)
        begin
            fw2_mem[s2_reg.idx] <= s2_reg.ltr;
        end
        fw2_rd_reg <= fw2_mem[addr3];
    end

    // Fast inverse bank: stage-3 lookup for decrypt
    always_ff @(posedge clk)
    begin
        if (wr_iv0)
        begin
            iv0_mem[s2_reg.ltr] <= s2_reg.idx;
        end
        iv0_rd_reg <= iv0_mem[addr3];
    end

    // ------------------------------------------------------------------
    // Output queue: every accepted word gets a slot, so stage 4 never stalls.
    // ------------------------------------------------------------------
    rsp_t rsp_word;

    always_comb
    begin
        rsp_word.letter_valid = s4_reg.xform;
        rsp_word.out_letter   = s4_reg.xform ? LETTER_W'(result) : '0;
    end

    assign rsp_valid = (oq_wr_ptr_reg != oq_rd_ptr_reg);
    assign rsp       = oq_mem[oq_rd_ptr_reg[OQ_PTR_W-1:0]];
    assign rsp_pop   = rsp_valid && rsp_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (req_acc && !rsp_pop)
        begin
            inflight_next = inflight_reg + CNT_W'(1);
        end
        else if (!req_acc && rsp_pop)
        begin
            inflight_next = inflight_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_vld_reg)
        begin
            oq_mem[oq_wr_ptr_reg[OQ_PTR_W-1:0]] <= rsp_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            inflight_reg  <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
            if (s4_vld_reg)
            begin
                oq_wr_ptr_reg <= oq_wr_ptr_reg + CNT_W'(1);
            end
            if (rsp_pop)
            begin
                oq_rd_ptr_reg <= oq_rd_ptr_reg + CNT_W'(1);
            end
        end
    end

endmodule
